### hdl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and codes of the open-address hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_UPDATE  = 3'd2,
    CMD_REPLACE = 3'd3,
    CMD_FIND    = 3'd4,
    CMD_DELETE  = 3'd5,
    CMD_NEXT    = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

### hdl/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/open_address_hash_table_top.sv
// ----------------------------------------------------------------------------
// open_address_hash_table_top
// Hash table of integer keys and values, open addressing, linear probing.
//
// One command transaction enters on the in channel (cmd, key, value, cursor)
// and gives exactly one result transaction on the out channel (status, slot,
// found_key, found_value, was_present). Commands run one at a time.
// Steps: the command is taken, then slots are probed in turn from the home
// slot (marks, keys and values sit in three RAMs read one slot a cycle), then
// the output register is loaded. When TABLE_SLOTS is not a power of two, the
// home slot is first reduced by a reciprocal multiplication: hash times
// reciprocal, quotient times TABLE_SLOTS, and one correction of the
// difference. Next-used-slot scans slot by slot from the cursor; clear all
// rewrites every mark. After reset the block sweeps the mark RAM and holds
// in_stall high meanwhile. A new command is taken while a result waits; a
// stalled out channel holds its transaction and blocks only the next result.
// ----------------------------------------------------------------------------
module open_address_hash_table_top #(
  parameter int TABLE_SLOTS = 256,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic [8:0]  cursor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  slot,
  output logic [31:0] found_key,
  output logic [31:0] found_value,
  output logic        was_present
);

  import oaht_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int KW      = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW      = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int HC_W    = 2;
  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] n, n_next;
  logic             have_del, have_del_next;
  logic [IDX_W-1:0] del_idx, del_idx_next;
  cmd_t             cmd_r, cmd_r_next;
  logic [KW-1:0]    key_r, key_r_next;
  logic [VW-1:0]    val_r, val_r_next;
  logic [IDX_W-1:0] clr_cnt, clr_cnt_next;
  logic             clr_emit, clr_emit_next;
  logic [KW-1:0]    h_r, h_r_next;
  logic [63:0]      prod, prod_next;
  logic [HC_W-1:0]  hcnt, hcnt_next;

  status_t          res_status, res_status_next;
  logic [IDX_W-1:0] res_slot, res_slot_next;
  logic [KW-1:0]    res_key, res_key_next;
  logic [VW-1:0]    res_val, res_val_next;
  logic             res_pres, res_pres_next;
  logic             out_valid_next;

  logic [IDX_W-1:0] rd_addr;
  logic [1:0]       mark_rd;
  logic [KW-1:0]    key_rd;
  logic [VW-1:0]    val_rd;
  logic             mark_we, key_we, val_we;
  logic [IDX_W-1:0] mark_waddr, kv_waddr;
  mark_t            mark_wdata;

  logic [KW-1:0]    kin, h_in;
  logic [31:0]      h32, h_diff, h_mod;
  logic [IDX_W-1:0] idx_inc, where;
  logic             hit_used, hit_empty, at_last, found;
  logic [15:0]      slot16;

  assign kin  = key[KW-1:0];
  assign h_in = kin ^ (kin >> 16);

  assign h32    = 32'(h_r);
  assign h_diff = h32 - prod[31:0];
  assign h_mod  = (h_diff >= 32'(TABLE_SLOTS)) ? h_diff - 32'(TABLE_SLOTS) : h_diff;

  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign hit_used  = (mark_t'(mark_rd) == MARK_USED) && (key_rd == key_r);
  assign hit_empty = mark_t'(mark_rd) == MARK_EMPTY;
  assign at_last   = n == CNT_W'(TABLE_SLOTS - 1);
  assign found     = hit_used || hit_empty || have_del ||
                     (mark_t'(mark_rd) == MARK_DELETED);
  assign where     = (hit_used || !have_del) ? idx : del_idx;

  oaht_ram #(.WIDTH(2), .DEPTH(TABLE_SLOTS)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(rd_addr), .rdata(mark_rd)
  );

  oaht_ram #(.WIDTH(KW), .DEPTH(TABLE_SLOTS)) u_key (
    .clk(clk), .we(key_we), .waddr(kv_waddr), .wdata(key_r),
    .raddr(rd_addr), .rdata(key_rd)
  );

  oaht_ram #(.WIDTH(VW), .DEPTH(TABLE_SLOTS)) u_val (
    .clk(clk), .we(val_we), .waddr(kv_waddr), .wdata(val_r),
    .raddr(rd_addr), .rdata(val_rd)
  );

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      clr_emit  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      clr_emit  <= clr_emit_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    n          <= n_next;
    have_del   <= have_del_next;
    del_idx    <= del_idx_next;
    cmd_r      <= cmd_r_next;
    key_r      <= key_r_next;
    val_r      <= val_r_next;
    h_r        <= h_r_next;
    prod       <= prod_next;
    hcnt       <= hcnt_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_key    <= res_key_next;
    res_val    <= res_val_next;
    res_pres   <= res_pres_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status      <= res_status;
      slot        <= slot16[7:0];
      found_key   <= 32'(res_key);
      found_value <= 32'(res_val);
      was_present <= res_pres;
    end
  end

  assign slot16 = 16'(res_slot);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    n_next          = n;
    have_del_next   = have_del;
    del_idx_next    = del_idx;
    cmd_r_next      = cmd_r;
    key_r_next      = key_r;
    val_r_next      = val_r;
    clr_cnt_next    = clr_cnt;
    clr_emit_next   = clr_emit;
    h_r_next        = h_r;
    prod_next       = prod;
    hcnt_next       = hcnt;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_key_next    = res_key;
    res_val_next    = res_val;
    res_pres_next   = res_pres;
    out_valid_next  = out_valid && out_stall;
    rd_addr         = idx;
    mark_we         = 1'b0;
    key_we          = 1'b0;
    val_we          = 1'b0;
    mark_waddr      = where;
    kv_waddr        = where;
    mark_wdata      = MARK_USED;

    unique case (state)
      S_CLR: begin
        mark_we      = 1'b1;
        mark_waddr   = clr_cnt;
        mark_wdata   = MARK_EMPTY;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == LAST_IDX) begin
          clr_cnt_next = '0;
          if (clr_emit) begin
            clr_emit_next   = 1'b0;
            res_status_next = ST_OK;
            res_slot_next   = '0;
            res_key_next    = '0;
            res_val_next    = '0;
            res_pres_next   = 1'b0;
            state_next      = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_r_next      = cmd_t'(cmd);
          key_r_next      = kin;
          val_r_next      = value[VW-1:0];
          n_next          = '0;
          have_del_next   = 1'b0;
          del_idx_next    = '0;
          res_status_next = ST_ABSENT;
          res_slot_next   = '0;
          res_key_next    = '0;
          res_val_next    = '0;
          res_pres_next   = 1'b0;
          if (cmd_t'(cmd) == CMD_CLEAR) begin
            clr_cnt_next  = '0;
            clr_emit_next = 1'b1;
            state_next    = S_CLR;
          end else if (cmd_t'(cmd) == CMD_NEXT) begin
            if (32'(cursor) >= 32'(TABLE_SLOTS)) begin
              state_next = S_DONE;
            end else begin
              idx_next   = IDX_W'(cursor);
              rd_addr    = IDX_W'(cursor);
              state_next = S_SCAN;
            end
          end else if (IS_POW2) begin
            idx_next   = h_in[IDX_W-1:0];
            rd_addr    = h_in[IDX_W-1:0];
            state_next = S_PROBE;
          end else begin
            h_r_next   = h_in;
            hcnt_next  = '0;
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        hcnt_next = hcnt + 1'b1;
        priority if (hcnt == HC_W'(0)) begin
          prod_next = 64'(h32) * 64'(RECIP);
        end else if (hcnt == HC_W'(1)) begin
          prod_next = 64'(prod[63:32]) * 64'(TABLE_SLOTS);
        end else begin
          idx_next   = h_mod[IDX_W-1:0];
          rd_addr    = h_mod[IDX_W-1:0];
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit_used || hit_empty || at_last) begin
          state_next    = S_DONE;
          res_slot_next = where;
          res_key_next  = hit_used ? key_rd : key_r;
          res_val_next  = hit_used ? val_rd : val_r;
          res_pres_next = 1'b0;
          if (!found) begin
            res_status_next = (cmd_r == CMD_ADD || cmd_r == CMD_CREATE ||
                               cmd_r == CMD_UPDATE) ? ST_FULL : ST_ABSENT;
          end else begin
            res_status_next = ST_OK;
            unique case (cmd_r)
              CMD_ADD, CMD_CREATE, CMD_UPDATE: begin
                if (hit_used) begin
                  res_pres_next = 1'b1;
                  if (cmd_r == CMD_CREATE) begin
                    res_status_next = ST_PRESENT;
                  end else if (cmd_r == CMD_UPDATE) begin
                    val_we       = 1'b1;
                    res_val_next = val_r;
                  end
                end else begin
                  mark_we = 1'b1;
                  key_we  = 1'b1;
                  val_we  = 1'b1;
                end
              end
              CMD_REPLACE: begin
                if (hit_used) begin
                  val_we       = 1'b1;
                  res_val_next = val_r;
                end else begin
                  res_status_next = ST_ABSENT;
                end
              end
              CMD_DELETE: begin
                if (hit_used) begin
                  mark_we    = 1'b1;
                  mark_wdata = MARK_DELETED;
                end else begin
                  res_status_next = ST_ABSENT;
                end
              end
              default: begin
                if (!hit_used) begin
                  res_status_next = ST_ABSENT;
                end
              end
            endcase
          end
          if (res_status_next != ST_OK) begin
            res_slot_next = '0;
            res_key_next  = '0;
            res_val_next  = '0;
            res_pres_next = 1'b0;
          end
        end else begin
          if (mark_t'(mark_rd) == MARK_DELETED && !have_del) begin
            have_del_next = 1'b1;
            del_idx_next  = idx;
          end
          idx_next = idx_inc;
          rd_addr  = idx_inc;
          n_next   = n + 1'b1;
        end
      end
      S_SCAN: begin
        if (mark_t'(mark_rd) == MARK_USED) begin
          res_status_next = ST_OK;
          res_slot_next   = idx;
          res_key_next    = key_rd;
          res_val_next    = val_rd;
          state_next      = S_DONE;
        end else if (idx == LAST_IDX) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + 1'b1;
          rd_addr  = idx + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("idle right after accepting a transaction");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      slot == 8'd0 && found_key == 32'd0 && found_value == 32'd0 && !was_present)
    else $error("failed result carries nonzero fields");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> 32'(n) < 32'(TABLE_SLOTS))
    else $error("probe ran past one lap");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the open-address hash table against a predictor of the table kept in
// the bench: directed commands, random well-formed workloads on a small key set
// and a table filled past capacity, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import oaht_pkg::*;

  localparam int SLOTS = 256;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic        was_present;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = CMD_FIND;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic [8:0]  cursor = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  slot;
  logic [31:0] found_key;
  logic [31:0] found_value;
  logic        was_present;

  mark_t       tbl_mark[SLOTS];
  logic [31:0] tbl_key[SLOTS];
  logic [31:0] tbl_value[SLOTS];
  answer_t     answers_due[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          idle_cycles = 0;
  int          sent = 0;
  int          checked = 0;
  logic [31:0] key_pool[16];

  open_address_hash_table_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .key(key), .value(value), .cursor(cursor), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .slot(slot), .found_key(found_key),
    .found_value(found_value), .was_present(was_present)
  );

  always #5 clk = ~clk;

  function automatic answer_t table_answer(status_t st, int idx, logic hit);
    answer_t a;
    a = '0;
    a.status = st;
    if (st == ST_OK && idx >= 0) begin
      a.slot = idx[7:0];
      a.found_key = tbl_key[idx];
      a.found_value = tbl_value[idx];
      a.was_present = hit;
    end
    return a;
  endfunction

  function automatic answer_t apply_command(cmd_t c, logic [31:0] k, logic [31:0] v,
                                            logic [8:0] cur);
    int idx, del_idx, where;
    logic have_del, ok, used;
    del_idx = 0;
    have_del = 1'b0;
    ok = 1'b0;
    where = 0;
    if (c == CMD_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_mark[i] = MARK_EMPTY;
        tbl_key[i] = '0;
        tbl_value[i] = '0;
      end
      return table_answer(ST_OK, -1, 1'b0);
    end
    if (c == CMD_NEXT) begin
      for (int i = cur; i < SLOTS; i++)
        if (tbl_mark[i] == MARK_USED) return table_answer(ST_OK, i, 1'b0);
      return table_answer(ST_ABSENT, -1, 1'b0);
    end
    idx = (k ^ (k >> 16)) & (SLOTS - 1);
    for (int n = 0; n < SLOTS && !ok; n++) begin
      if (tbl_mark[idx] == MARK_EMPTY) begin
        where = have_del ? del_idx : idx;
        ok = 1'b1;
      end else if (tbl_mark[idx] == MARK_USED && tbl_key[idx] == k) begin
        where = idx;
        ok = 1'b1;
      end else begin
        if (tbl_mark[idx] == MARK_DELETED && !have_del) begin
          have_del = 1'b1;
          del_idx = idx;
        end
        idx = (idx + 1) % SLOTS;
      end
    end
    if (!ok && have_del) begin
      where = del_idx;
      ok = 1'b1;
    end
    if (!ok)
      return table_answer((c <= CMD_UPDATE) ? ST_FULL : ST_ABSENT, -1, 1'b0);
    used = (tbl_mark[where] == MARK_USED);
    case (c)
      CMD_ADD, CMD_CREATE, CMD_UPDATE: begin
        if (used) begin
          if (c == CMD_CREATE) return table_answer(ST_PRESENT, -1, 1'b0);
          if (c == CMD_UPDATE) tbl_value[where] = v;
          return table_answer(ST_OK, where, 1'b1);
        end
        tbl_mark[where] = MARK_USED;
        tbl_key[where] = k;
        tbl_value[where] = v;
        return table_answer(ST_OK, where, 1'b0);
      end
      CMD_REPLACE: begin
        if (!used) return table_answer(ST_ABSENT, -1, 1'b0);
        tbl_value[where] = v;
        return table_answer(ST_OK, where, 1'b0);
      end
      CMD_FIND: begin
        if (!used) return table_answer(ST_ABSENT, -1, 1'b0);
        return table_answer(ST_OK, where, 1'b0);
      end
      default: begin
        if (!used) return table_answer(ST_ABSENT, -1, 1'b0);
        tbl_mark[where] = MARK_DELETED;
        return table_answer(ST_OK, where, 1'b0);
      end
    endcase
  endfunction

  // valid stays high after a transaction until the next one or an idle cycle
  task automatic send_command(cmd_t c, logic [31:0] k, logic [31:0] v, logic [8:0] cur);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    cursor <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    answers_due.push_back(apply_command(c, k, v, cur));
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // receiver stall and result checking
  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d slot=%0d", $time, status, slot);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (status != want.status || slot != want.slot || found_key != want.found_key ||
              found_value != want.found_value || was_present != want.was_present) begin
            $display("%0t: mismatch expected st=%0d slot=%0d key=%h val=%h pres=%0b",
                     $time, want.status, want.slot, want.found_key, want.found_value,
                     want.was_present);
            $display("%0t:          actual st=%0d slot=%0d key=%h val=%h pres=%0b",
                     $time, status, slot, found_key, found_value, was_present);
            errors++;
          end
        end
      end
      out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(CMD_FIND, 32'h0, 32'h0, 9'd0);
    send_command(CMD_NEXT, 32'h0, 32'h0, 9'd0);
    send_command(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 9'd0);
    send_command(CMD_ADD, 32'h0, 32'h1234, 9'd0);
    send_command(CMD_CREATE, 32'h0, 32'h5, 9'd0);
    send_command(CMD_CREATE, 32'hFFFF_FFFF, 32'h0, 9'd0);
    send_command(CMD_CREATE, 32'h0001_0001, 32'hA5A5_A5A5, 9'd0);
    send_command(CMD_UPDATE, 32'h0001_0001, 32'h5A5A_5A5A, 9'd0);
    send_command(CMD_UPDATE, 32'hDEAD_BEEF, 32'h1, 9'd0);
    send_command(CMD_REPLACE, 32'h0, 32'h7777, 9'd0);
    send_command(CMD_REPLACE, 32'h0000_0FF0, 32'h1, 9'd0);
    send_command(CMD_DELETE, 32'h0, 32'h0, 9'd0);
    send_command(CMD_DELETE, 32'h0, 32'h0, 9'd0);
    send_command(CMD_FIND, 32'h0001_0001, 32'h0, 9'd0);
    send_command(CMD_ADD, 32'h0000_0100, 32'h9, 9'd0);
    send_command(CMD_NEXT, 32'h0, 32'h0, 9'd255);
    send_command(CMD_NEXT, 32'h0, 32'h0, 9'd256);
    send_command(CMD_NEXT, 32'h0, 32'h0, 9'd511);
    send_command(CMD_CLEAR, 32'h0, 32'h0, 9'd0);
    send_command(CMD_FIND, 32'hFFFF_FFFF, 32'h0, 9'd0);
  endtask

  // fills the table past capacity so full and lap-around probes occur
  task automatic test_full_table();
    for (int i = 0; i < SLOTS + 4; i++)
      send_command(CMD_CREATE, $urandom(), $urandom(), 9'd0);
    send_command(CMD_FIND, 32'h0BAD_0000, 32'h0, 9'd0);
    for (int i = 0; i < 6; i++) send_command(CMD_DELETE, key_pool[0], 32'h0, 9'd0);
    send_command(CMD_NEXT, 32'h0, 32'h0, 9'd0);
    wait_drained();
    send_command(CMD_CLEAR, 32'h0, 32'h0, 9'd0);
  endtask

  task automatic test_random(int count);
    cmd_t c;
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) k = $urandom();
      else k = key_pool[$urandom_range(15)];
      c = cmd_t'($urandom_range(6));
      if ($urandom_range(199) == 0) c = CMD_CLEAR;
      send_command(c, k, $urandom(), 9'($urandom_range(511)));
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_mark[i] = MARK_EMPTY;
      tbl_key[i] = '0;
      tbl_value[i] = '0;
    end
    // colliding keys share home slots, forcing probe chains and tombstones
    for (int i = 0; i < 16; i++)
      key_pool[i] = (i < 8) ? ((32'(i) << 24) | 32'h40) : $urandom();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle = 23;
    recv_idle = 84;
    test_random(220);
    send_idle = 84;
    recv_idle = 23;
    test_full_table();
    test_random(220);
    send_idle = 0;
    recv_idle = 0;
    test_random(221);
    wait_drained();
    repeat (600) @(posedge clk);
    $display("Covered %0d commands, %0d results checked, all commands incl. full table,",
             sent, checked);
    $display("tombstone reuse, scans with out-of-range cursors and clear-all.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
